>>> hw/rtl/rpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpd_pkg
// Shared types and constants for the residual predictor decoder.
// ----------------------------------------------------------------------------
package rpd_pkg;

   localparam int unsigned DATA_W       = 32;
   localparam int unsigned MODE_W       = 3;
   localparam int unsigned PRIMER_COUNT = 4;
   localparam int signed   STRIP_LIMIT  = 8;
   localparam int unsigned STRIP_STEP   = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_LAG1    = 3'd0,
      MODE_LAG2    = 3'd1,
      MODE_XOR1    = 3'd2,
      MODE_XOR2    = 3'd3,
      MODE_STRIDE1 = 3'd4,
      MODE_STRIDE2 = 3'd5,
      MODE_STRIP   = 3'd6,
      MODE_RAMP    = 3'd7
   } mode_type;

   // decoder state seen by the prediction logic
   typedef struct packed {
      logic [DATA_W-1:0] v1;
      logic [DATA_W-1:0] v2;
      logic [DATA_W-1:0] v4;
      logic [DATA_W-1:0] item_index;
   } pred_state_type;

endpackage

>>> hw/rtl/rpd_decode_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpd_decode_unit
// Forms the prediction for the selected mode and decodes one residual.
// ----------------------------------------------------------------------------
module rpd_decode_unit (
   input  rpd_pkg::mode_type          mode,
   input  rpd_pkg::pred_state_type    state,
   input  logic [rpd_pkg::DATA_W-1:0] residual,
   output logic [rpd_pkg::DATA_W-1:0] value
);
   import rpd_pkg::*;

   logic [DATA_W-1:0] d12;
   logic [DATA_W-1:0] d24;
   logic              strip_near;
   logic [DATA_W-1:0] pred;
   logic              primer;

   assign d12 = state.v1 - state.v2;
   assign d24 = state.v2 - state.v4;
   assign strip_near = ($signed(d24) < $signed(STRIP_LIMIT[DATA_W-1:0])) &&
                       ($signed(d24) > -$signed(STRIP_LIMIT[DATA_W-1:0]));
   assign primer = state.item_index < PRIMER_COUNT[DATA_W-1:0];

   always_comb begin
      unique case (mode)
         MODE_LAG2, MODE_XOR2: pred = state.v2;
         MODE_STRIDE1:         pred = state.v1 + d12;
         MODE_STRIDE2:         pred = state.v2 + d24;
         MODE_STRIP: begin
            if (strip_near) begin
               pred = state.v2 + d24;
            end else begin
               pred = state.v2 + STRIP_STEP[DATA_W-1:0];
            end
         end
         MODE_RAMP:            pred = state.item_index;
         default:              pred = state.v1;
      endcase
   end

   always_comb begin
      if (primer) begin
         value = residual;
      end else if (mode == MODE_XOR1 || mode == MODE_XOR2) begin
         value = residual ^ pred;
      end else begin
         value = residual + pred;
      end
   end

endmodule

>>> hw/rtl/residual_predictor_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// residual_predictor_decode
// Decodes a stream of prediction residuals back into values.
// ----------------------------------------------------------------------------
// Path: an accepted req item passes the input reg, then the result reg, to rsp_tvalid.
// Throughput: 1 item per cycle while rsp_tready does not hold the result register;
//   history and index update as an item enters it, ready for the next prediction.
// Reset: synchronous, active high; clears mode (lag1), history, index, valids.
module residual_predictor_decode (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [rpd_pkg::DATA_W-1:0]    req_tdata,   // [31:0] residual
   input  logic                          req_tlast,   // last_in
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [rpd_pkg::DATA_W-1:0]    rsp_tdata,   // [31:0] value
   output logic                          rsp_tlast,   // last_out
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rpd_pkg::MODE_W-1:0]    csr_data     // [2:0] predictor_mode
);
   import rpd_pkg::*;

   mode_type          mode_ff;
   logic              in_vld_ff;
   logic [DATA_W-1:0] in_res_ff;
   logic              in_last_ff;
   logic              out_vld_ff;
   logic [DATA_W-1:0] out_val_ff;
   logic              out_last_ff;
   logic [DATA_W-1:0] hist_ff [4];
   logic [DATA_W-1:0] index_ff;
   logic              advance;
   logic [DATA_W-1:0] value;
   pred_state_type    state;

   assign advance    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_val_ff;
   assign rsp_tlast  = out_last_ff;

   assign state.v1         = hist_ff[0];
   assign state.v2         = hist_ff[1];
   assign state.v4         = hist_ff[3];
   assign state.item_index = index_ff;

   rpd_decode_unit u_decode (
      .mode     (mode_ff),
      .state    (state),
      .residual (in_res_ff),
      .value    (value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_LAG1;
      end else if (csr_valid) begin
         mode_ff <= mode_type'(csr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_res_ff  <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_val_ff  <= value;
         out_last_ff <= in_last_ff;
      end
   end

   // history shift / block end
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff  <= '{default: '0};
         index_ff <= '0;
      end else if (advance) begin
         if (in_last_ff) begin
            hist_ff  <= '{default: '0};
            index_ff <= '0;
         end else begin
            hist_ff[3] <= hist_ff[2];
            hist_ff[2] <= hist_ff[1];
            hist_ff[1] <= hist_ff[0];
            hist_ff[0] <= value;
            index_ff   <= index_ff + 1'b1;
         end
      end
   end

endmodule

>>> test/residual_predictor_decode_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// residual_predictor_decode_checker
// Watches the req, rsp and csr channels of the residual predictor decoder.
// It keeps its own history, item index and mode, works out the decoded value
// of every accepted residual, and compares each rsp item in order against it.
// ----------------------------------------------------------------------------
module residual_predictor_decode_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [rpd_pkg::DATA_W-1:0] req_tdata,   // [31:0] residual
   input  logic                       req_tlast,   // last_in
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [rpd_pkg::DATA_W-1:0] rsp_tdata,   // [31:0] value
   input  logic                       rsp_tlast,   // last_out
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [rpd_pkg::MODE_W-1:0] csr_data,    // [2:0] predictor_mode
   output int                         mismatch_count,
   output int                         values_pending
);
   import rpd_pkg::*;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              last;
   } decoded_type;

   decoded_type       expected_values[$];
   mode_type          mode;
   logic [DATA_W-1:0] history [4];   // index 0 is the newest value
   logic [DATA_W-1:0] item_index;
   int                failures = 0;

   initial begin
      mismatch_count = 0;
      values_pending = 0;
   end

   always @(posedge clock) begin
      logic [DATA_W-1:0] v1, v2, v4, d24, prediction, value;
      decoded_type       want;
      if (reset) begin
         expected_values.delete();
         mode       = MODE_LAG1;
         history    = '{default: '0};
         item_index = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            mode = mode_type'(csr_data);
         end
         if (req_tvalid && req_tready) begin
            v1  = history[0];
            v2  = history[1];
            v4  = history[3];
            d24 = v2 - v4;
            case (mode)
               MODE_LAG2, MODE_XOR2: prediction = v2;
               MODE_STRIDE1:         prediction = v1 + (v1 - v2);
               MODE_STRIDE2:         prediction = v2 + d24;
               MODE_STRIP: begin
                  if ($signed(d24) < STRIP_LIMIT && $signed(d24) > -STRIP_LIMIT) begin
                     prediction = v2 + d24;
                  end else begin
                     prediction = v2 + STRIP_STEP;
                  end
               end
               MODE_RAMP:            prediction = item_index;
               default:              prediction = v1;
            endcase
            if (item_index < PRIMER_COUNT) begin
               value = req_tdata;
            end else if (mode == MODE_XOR1 || mode == MODE_XOR2) begin
               value = req_tdata ^ prediction;
            end else begin
               value = req_tdata + prediction;
            end
            expected_values.push_back('{value: value, last: req_tlast});
            if (req_tlast) begin
               history    = '{default: '0};
               item_index = '0;
            end else begin
               history[3] = history[2];
               history[2] = history[1];
               history[1] = history[0];
               history[0] = value;
               item_index = item_index + 1;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_values.size() == 0) begin
               $error("rsp item with nothing expected: value %0d, last_out %0b",
                      $signed(rsp_tdata), rsp_tlast);
               failures++;
            end else begin
               want = expected_values.pop_front();
               if (rsp_tdata !== want.value) begin
                  $error("value: expected %0d, got %0d",
                         $signed(want.value), $signed(rsp_tdata));
                  failures++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last_out: expected %0b, got %0b", want.last, rsp_tlast);
                  failures++;
               end
            end
         end
      end
      values_pending <= expected_values.size();
      mismatch_count <= failures;
   end

endmodule

>>> test/tb_residual_predictor_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_residual_predictor_decode
// Stimulus and verdict for the residual predictor decoder. A few hand-made
// blocks probe the strip-index clamp, then random blocks run under every mode
// with idling heavier on the receiver, heavier on the sender, or none. Checking
// is done by the checker instance.
// ----------------------------------------------------------------------------
module tb_residual_predictor_decode;
   import rpd_pkg::*;

   localparam int unsigned PHASES     = 12;
   localparam int unsigned PHASE_SIZE = 83;

   // four primers then one predicted item, strip-index mode
   localparam logic [DATA_W-1:0] STRIP_CASES [5][5] = '{
      '{32'd0,         32'h7FFF_FFFF, 32'd7,         32'h8000_0000, 32'd1},
      '{32'd0,         32'hFFFF_FFFF, 32'd8,         32'd0,         32'hFFFF_FFFF},
      '{32'd10,        32'd0,         32'd3,         32'd5,         32'h7FFF_FFFF},
      '{32'd10,        32'd1,         32'd2,         32'hFFFF_FFFF, 32'h8000_0000},
      '{32'h7FFF_FFFF, 32'd3,         32'h8000_0000, 32'd4,         32'd5}
   };

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata  = '0;
   logic              req_tlast  = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;
   logic              rsp_tlast;
   logic              csr_valid  = 1'b0;
   logic              csr_ready;
   logic [MODE_W-1:0] csr_data   = '0;

   int                mismatch_count;
   int                values_pending;
   int unsigned       tx_idle_pct = 33;
   int unsigned       rx_idle_pct = 63;

   residual_predictor_decode dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   residual_predictor_decode_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .values_pending (values_pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   initial begin
      #2_000_000;
      $display("** residual_predictor_decode: FAILED **");
      $finish;
   end

   task automatic send_residual(input logic [DATA_W-1:0] residual, input logic last);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= residual;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // mode changes only once every value has come back
   task automatic write_mode(input mode_type mode);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (values_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= mode;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int unsigned       sent;
      int unsigned       block_len;
      int unsigned       wait_cycles;
      logic [DATA_W-1:0] residual;
      mode_type          mode;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      write_mode(MODE_STRIP);
      foreach (STRIP_CASES[c, i]) begin
         send_residual(STRIP_CASES[c][i], i == 4);
      end

      for (int unsigned phase = 0; phase < PHASES; phase++) begin
         mode = (phase < 8) ? mode_type'((phase * 3) % 8) : mode_type'($urandom_range(0, 7));
         write_mode(mode);
         case (phase / 4)
            0: begin
               tx_idle_pct = 33;
               rx_idle_pct <= 63;
            end
            1: begin
               tx_idle_pct = 63;
               rx_idle_pct <= 33;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct <= 0;
            end
         endcase
         sent = 0;
         while (sent < PHASE_SIZE) begin
            block_len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4)
                                                     : $urandom_range(5, 24);
            for (int unsigned k = 0; k < block_len; k++) begin
               case ($urandom_range(0, 7))
                  0, 1, 2, 3: residual = $urandom_range(0, 32) - 16;
                  4, 5:       residual = $urandom();
                  6: begin
                     case ($urandom_range(0, 3))
                        0:       residual = 32'h8000_0000;
                        1:       residual = 32'h7FFF_FFFF;
                        2:       residual = 32'h0000_0000;
                        default: residual = 32'hFFFF_FFFF;
                     endcase
                  end
                  default:    residual = 32'd1 << $urandom_range(0, 31);
               endcase
               send_residual(residual, k == block_len - 1);
            end
            sent += block_len;
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      for (wait_cycles = 0; values_pending != 0 && wait_cycles < 10000; wait_cycles++) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);

      if (mismatch_count == 0 && values_pending == 0) begin
         $display("** residual_predictor_decode: PASSED **");
      end else begin
         $display("** residual_predictor_decode: FAILED **");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/rpd_pkg.sv
hw/rtl/rpd_decode_unit.sv
hw/rtl/residual_predictor_decode.sv
test/residual_predictor_decode_checker.sv
test/tb_residual_predictor_decode.sv
